// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPL(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== src/hsv2rgb_pkg.sv =====
`default_nettype none

package hsv2rgb_pkg;

  // Field widths.
  localparam int unsigned HUE_W = 9;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned CH_W  = 8;

  // Pipeline depth: sector, product, chroma, sum, scale, divide.
  localparam int unsigned STAGES = 6;

  // Internal widths.
  localparam int unsigned K_W     = 6;   // k runs 0..60
  localparam int unsigned HM_W    = 7;   // hue within a 120-degree pair, 0..119
  localparam int unsigned SV_W    = 14;  // S*V up to 10000
  localparam int unsigned NUM_W   = 20;  // numerators up to 600000
  localparam int unsigned Y_W     = 24;  // 17*numerator up to 10200000
  localparam int unsigned T_W     = 18;  // 17*numerator/64
  localparam int unsigned RECIP_W = 19;
  localparam int unsigned QP_W    = T_W + RECIP_W;

  // Constants.
  localparam logic [HUE_W-1:0] HUE_TURN   = 9'd360;
  localparam logic [HUE_W-1:0] SECTOR_DEG = 9'd60;
  localparam logic [HUE_W-1:0] PAIR_DEG   = 9'd120;
  localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
  localparam logic [NUM_W-1:0] C_SCALE    = 20'd60;
  localparam logic [NUM_W-1:0] V_SCALE    = 20'd6000;

  // 255/600000 reduces to 17/40000 = 17 / (64 * 625).
  localparam logic [Y_W-1:0]     SCALE_MUL   = 24'd17;
  localparam int unsigned        SCALE_SHIFT = 6;
  // ceil(2^28 / 625); exact floor division by 625 for any 18-bit dividend.
  localparam logic [RECIP_W-1:0] RECIP       = 19'd429497;
  localparam int unsigned        RECIP_SHIFT = 28;

  // Hue sectors, 60 degrees each.
  typedef enum logic [2:0] {
    SEC_RY,
    SEC_YG,
    SEC_GC,
    SEC_CB,
    SEC_BM,
    SEC_MR
  } sector_t;

  // First-stage result handed to the chroma pipeline.
  typedef struct packed {
    sector_t          sector;
    logic [K_W-1:0]   k;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
  } s1_t;

endpackage

`default_nettype wire

// ===== src/hsv_to_rgb888_core.sv =====
`default_nettype none

// HSV to RGB888 converter. A transaction on the input channel carries a hue
// in whole degrees (360 and above wrap by one turn) and saturation and
// brightness in percent (values above 100 count as 100); the matching output
// transaction carries 8-bit red, green and blue, truncated from
// 255*(channel + m), and the same three packed as red in 23:16, green in
// 15:8, blue in 7:0. The arithmetic is exact fixed point, so results match
// the floor of the ideal conversion bit for bit. The block is a six-stage
// pipeline: hue sector and clamping, the S*V product, chroma and X, the
// per-channel sums, and two stages that divide by the common denominator
// through a reciprocal multiply. One transaction per cycle is sustained while
// out_ready stays high. Every stage carries its own valid bit and loads
// whenever it is empty or the stage after it moves, so a stalled output only
// holds the items that are stuck behind it and bubbles are squeezed out;
// in_ready therefore depends combinationally on out_ready through that valid
// chain. There is no configuration and no state beyond the pipeline itself.
module hsv_to_rgb888_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [hsv2rgb_pkg::HUE_W-1:0] in_hue,
  input  wire logic [hsv2rgb_pkg::PCT_W-1:0] in_saturation,
  input  wire logic [hsv2rgb_pkg::PCT_W-1:0] in_brightness,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [hsv2rgb_pkg::CH_W-1:0]  out_red,
  output logic      [hsv2rgb_pkg::CH_W-1:0]  out_green,
  output logic      [hsv2rgb_pkg::CH_W-1:0]  out_blue,
  output logic      [3*hsv2rgb_pkg::CH_W-1:0] out_packed_rgb
);
  import hsv2rgb_pkg::*;

  logic [STAGES-1:0] valid_r, valid_nxt;
  logic [STAGES-1:0] stg_en;
  s1_t               s1;
  logic [NUM_W-1:0]  num_red, num_green, num_blue;

  // A stage may load when it holds nothing or its successor is loading.
  always_comb begin
    stg_en[STAGES-1] = !valid_r[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      stg_en[i] = !valid_r[i] || stg_en[i+1];
    end
  end

  // Valid bits move in step with the data registers of each stage.
  always_comb begin
    valid_nxt[0] = stg_en[0] ? in_valid : valid_r[0];
    for (int i = 1; i < STAGES; i++) begin
      valid_nxt[i] = stg_en[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = stg_en[0];
  assign out_valid = valid_r[STAGES-1];

  // Stage 1: hue wrap, sector, k and percent clamping.
  hsv2rgb_sector u_sector (
    .clk  (clk),
    .en   (stg_en[0]),
    .hue  (in_hue),
    .sat  (in_saturation),
    .val  (in_brightness),
    .s1_r (s1)
  );

  // Stages 2 to 4: products, chroma and per-channel numerators.
  hsv2rgb_chroma u_chroma (
    .clk         (clk),
    .en          (stg_en[3:1]),
    .s1          (s1),
    .num_red_r   (num_red),
    .num_green_r (num_green),
    .num_blue_r  (num_blue)
  );

  // Stages 5 and 6: scaling by 255/600000, one unit per channel.
  hsv2rgb_scale u_scale_red (
    .clk    (clk),
    .en     (stg_en[5:4]),
    .num    (num_red),
    .chan_r (out_red)
  );

  hsv2rgb_scale u_scale_green (
    .clk    (clk),
    .en     (stg_en[5:4]),
    .num    (num_green),
    .chan_r (out_green)
  );

  hsv2rgb_scale u_scale_blue (
    .clk    (clk),
    .en     (stg_en[5:4]),
    .num    (num_blue),
    .chan_r (out_blue)
  );

  assign out_packed_rgb = {out_red, out_green, out_blue};

endmodule

`default_nettype wire

// ===== src/hsv2rgb_sector.sv =====
`default_nettype none

module hsv2rgb_sector (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [hsv2rgb_pkg::HUE_W-1:0] hue,
  input  wire logic [hsv2rgb_pkg::PCT_W-1:0] sat,
  input  wire logic [hsv2rgb_pkg::PCT_W-1:0] val,
  output hsv2rgb_pkg::s1_t                   s1_r
);
  import hsv2rgb_pkg::*;

  logic [HUE_W-1:0] hue_w;
  logic [HUE_W-1:0] base;
  logic [HUE_W-1:0] hm_full;
  logic [HM_W-1:0]  hm;
  s1_t              s1_nxt;

  always_comb begin
    hue_w = (hue >= HUE_TURN) ? hue - HUE_TURN : hue;

    priority if (hue_w < SECTOR_DEG) begin
      s1_nxt.sector = SEC_RY;
    end else if (hue_w < 9'(2 * SECTOR_DEG)) begin
      s1_nxt.sector = SEC_YG;
    end else if (hue_w < 9'(3 * SECTOR_DEG)) begin
      s1_nxt.sector = SEC_GC;
    end else if (hue_w < 9'(4 * SECTOR_DEG)) begin
      s1_nxt.sector = SEC_CB;
    end else if (hue_w < 9'(5 * SECTOR_DEG)) begin
      s1_nxt.sector = SEC_BM;
    end else begin
      s1_nxt.sector = SEC_MR;
    end

    unique case (s1_nxt.sector)
      SEC_RY, SEC_YG: base = '0;
      SEC_GC, SEC_CB: base = PAIR_DEG;
      default:        base = 9'(2 * PAIR_DEG);
    endcase

    hm_full = hue_w - base;
    hm      = hm_full[HM_W-1:0];

    // Distance from the nearest primary: rises 0..60 then falls back.
    if (hm >= HM_W'(SECTOR_DEG)) begin
      s1_nxt.k = K_W'(HM_W'(PAIR_DEG) - hm);
    end else begin
      s1_nxt.k = K_W'(hm);
    end

    s1_nxt.sat = (sat > PCT_MAX) ? PCT_MAX : sat;
    s1_nxt.val = (val > PCT_MAX) ? PCT_MAX : val;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/hsv2rgb_chroma.sv =====
`default_nettype none

module hsv2rgb_chroma (
  input  wire logic                          clk,
  input  wire logic [2:0]                    en,
  input  wire hsv2rgb_pkg::s1_t              s1,
  output logic      [hsv2rgb_pkg::NUM_W-1:0] num_red_r,
  output logic      [hsv2rgb_pkg::NUM_W-1:0] num_green_r,
  output logic      [hsv2rgb_pkg::NUM_W-1:0] num_blue_r
);
  import hsv2rgb_pkg::*;

  // Stage 2: S*V and 6000*V.
  logic [SV_W-1:0]  sv_r, sv_nxt;
  logic [NUM_W-1:0] v6k2_r, v6k2_nxt;
  sector_t          sector2_r;
  logic [K_W-1:0]   k2_r;

  // Stage 3: chroma C and the intermediate X.
  logic [NUM_W-1:0] c_r, c_nxt;
  logic [NUM_W-1:0] x_r, x_nxt;
  logic [NUM_W-1:0] v6k3_r;
  sector_t          sector3_r;

  // Stage 4: per-channel numerators.
  logic [NUM_W-1:0] m;
  logic [NUM_W-1:0] part_red, part_green, part_blue;
  logic [NUM_W-1:0] num_red_nxt, num_green_nxt, num_blue_nxt;

  assign sv_nxt   = SV_W'(s1.sat) * SV_W'(s1.val);
  assign v6k2_nxt = NUM_W'(s1.val) * V_SCALE;
  assign c_nxt    = NUM_W'(sv_r) * C_SCALE;
  assign x_nxt    = NUM_W'(sv_r) * NUM_W'(k2_r);

  always_comb begin
    m = v6k3_r - c_r;
    unique case (sector3_r)
      SEC_RY: begin part_red = c_r; part_green = x_r; part_blue = '0;  end
      SEC_YG: begin part_red = x_r; part_green = c_r; part_blue = '0;  end
      SEC_GC: begin part_red = '0;  part_green = c_r; part_blue = x_r; end
      SEC_CB: begin part_red = '0;  part_green = x_r; part_blue = c_r; end
      SEC_BM: begin part_red = x_r; part_green = '0;  part_blue = c_r; end
      default: begin part_red = c_r; part_green = '0; part_blue = x_r; end
    endcase
    num_red_nxt   = part_red + m;
    num_green_nxt = part_green + m;
    num_blue_nxt  = part_blue + m;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sv_r      <= sv_nxt;
      v6k2_r    <= v6k2_nxt;
      sector2_r <= s1.sector;
      k2_r      <= s1.k;
    end
    if (en[1]) begin
      c_r       <= c_nxt;
      x_r       <= x_nxt;
      v6k3_r    <= v6k2_r;
      sector3_r <= sector2_r;
    end
    if (en[2]) begin
      num_red_r   <= num_red_nxt;
      num_green_r <= num_green_nxt;
      num_blue_r  <= num_blue_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/hsv2rgb_scale.sv =====
`default_nettype none

module hsv2rgb_scale (
  input  wire logic                          clk,
  input  wire logic [1:0]                    en,
  input  wire logic [hsv2rgb_pkg::NUM_W-1:0] num,
  output logic      [hsv2rgb_pkg::CH_W-1:0]  chan_r
);
  import hsv2rgb_pkg::*;

  logic [Y_W-1:0]  y;
  logic [T_W-1:0]  t_r, t_nxt;
  logic [QP_W-1:0] qp;
  logic [CH_W-1:0] chan_nxt;

  // floor(17*num/40000): the factor 64 of the divisor is a shift, the
  // remaining 625 a reciprocal multiply that is exact over the 18-bit range.
  assign y        = Y_W'(num) * SCALE_MUL;
  assign t_nxt    = y[Y_W-1:SCALE_SHIFT];
  assign qp       = QP_W'(t_r) * QP_W'(RECIP);
  assign chan_nxt = qp[RECIP_SHIFT +: CH_W];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_r <= t_nxt;
    end
    if (en[1]) begin
      chan_r <= chan_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/hsv2rgb_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module hsv2rgb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [8:0]  in_hue,
  input wire logic [6:0]  in_saturation,
  input wire logic [6:0]  in_brightness,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_red,
  input wire logic [7:0]  out_green,
  input wire logic [7:0]  out_blue,
  input wire logic [23:0] out_packed_rgb
);

  // The packed word always agrees with the separate channels.
  `ASSERT_IMPL(a_packed, clk, !rst_n, out_valid, out_packed_rgb == {out_red, out_green, out_blue})

  // A draining output lets the whole pipeline move, so in_ready is high.
  `ASSERT_IMPL(a_ready_flow, clk, !rst_n, out_ready, in_ready)

  // Reset empties the pipeline.
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid)

  // A stalled result stays put.
  `ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(out_packed_rgb))

endmodule

bind hsv_to_rgb888_core hsv2rgb_checker u_hsv2rgb_checker (.*);

`default_nettype wire
